### rtl/mft_pkg.sv
package mft_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int DEPTH       = 16;
  localparam int CAPACITY    = (MAX_ENTRIES < DEPTH) ? MAX_ENTRIES : DEPTH;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_FREEZE = 3'd0;
  localparam logic [2:0] MODE_THAW   = 3'd1;
  localparam logic [2:0] MODE_QUERY  = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_APPLY  = 3'd4;
  localparam logic [2:0] MODE_SET    = 3'd5;

  // input word
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [3:0]  index;
  } mft_in_t;

  // result word
  typedef struct packed {
    logic        ok;
    logic        hit;
    logic [15:0] read_addr;
    logic [7:0]  read_value;
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [4:0]  live_entries;
    logic        last;
  } mft_out_t;

  // one stored table entry
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
  } mft_entry_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_READ,
    ST_DATA,
    ST_EMIT
  } mft_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic do_match;
    logic do_read;
    logic do_move;
    logic load_out;
    logic ptr_inc;
  } mft_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic apply_more;
  } mft_sts_t;

endpackage

### rtl/mft_ctrl.sv
module mft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mft_pkg::mft_sts_t sts,
  output mft_pkg::mft_cmd_t cmd
);
  import mft_pkg::*;

  mft_state_t state_r;
  mft_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MATCH;
      end
      ST_MATCH: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_DATA;
      ST_DATA:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.apply_more ? ST_READ : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_MATCH: cmd.do_match = 1'b1;
      ST_READ:  cmd.do_read  = 1'b1;
      ST_DATA:  cmd.do_move  = 1'b1;
      ST_EMIT: begin
        cmd.load_out = sts.out_free;
        cmd.ptr_inc  = sts.out_free & sts.apply_more;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/mft_datapath.sv
module mft_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  mft_pkg::mft_in_t   in_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  mft_pkg::mft_cmd_t  cmd,
  output mft_pkg::mft_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output mft_pkg::mft_out_t  out_data
);
  import mft_pkg::*;

  mft_in_t    item_r;
  logic       enabled_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [15:0] tag_r [DEPTH];
  mft_entry_t entry_mem [DEPTH];
  mft_entry_t rd_r;
  logic       hit_r;
  logic [IDX_W-1:0] slot_r;
  logic       ok_r;
  logic       ok_nxt;
  logic [IDX_W-1:0] ptr_r;
  logic       out_valid_r;
  mft_out_t   out_data_r;

  logic       hit_c;
  logic [IDX_W-1:0] slot_c;
  logic       full;
  logic [IDX_W-1:0] rd_idx;
  logic       wr_en;
  logic [IDX_W-1:0] wr_idx;
  mft_entry_t wr_entry;
  logic       apply_active;
  logic       apply_more;
  mft_out_t   out_c;

  // item capture and configuration
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
    end else if (cfg_wr_en) begin
      enabled_r <= cfg_wr_data;
    end
  end

  // parallel address compare over live entries, lowest slot wins
  always_comb begin
    hit_c  = 1'b0;
    slot_c = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_r) && (tag_r[i] == item_r.addr)) begin
        hit_c  = 1'b1;
        slot_c = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_match) begin
      hit_r  <= hit_c;
      slot_r <= slot_c;
    end
  end

  assign full = (count_r >= CNT_W'(CAPACITY));

  // read address select
  always_comb begin
    case (item_r.mode)
      MODE_THAW:  rd_idx = IDX_W'(count_r - CNT_W'(1));
      MODE_QUERY: rd_idx = slot_r;
      MODE_READ:  rd_idx = item_r.index[IDX_W-1:0];
      MODE_APPLY: rd_idx = ptr_r;
      default:    rd_idx = slot_r;
    endcase
  end

  // table update: freeze writes while reading, thaw moves the last entry
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = slot_r;
    wr_entry  = '{addr: item_r.addr, value: item_r.value};
    count_nxt = count_r;
    ok_nxt    = ok_r;
    if (cmd.do_read) begin
      case (item_r.mode)
        MODE_FREEZE: begin
          ok_nxt = hit_r | ~full;
          if (hit_r) begin
            wr_en = 1'b1;
          end else if (!full) begin
            wr_en     = 1'b1;
            wr_idx    = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_THAW: ok_nxt = hit_r;
        default:   ok_nxt = ok_r;
      endcase
    end else if (cmd.do_move && (item_r.mode == MODE_THAW) && ok_r) begin
      wr_en     = 1'b1;
      wr_entry  = rd_r;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  // entry storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_idx] <= wr_entry;
      tag_r[wr_idx]     <= wr_entry.addr;
    end
    if (cmd.do_read) rd_r <= entry_mem[rd_idx];
  end

  // apply walk pointer
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      ptr_r <= '0;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + IDX_W'(1);
    end
  end

  assign apply_active = (item_r.mode == MODE_APPLY) && enabled_r && (count_r != '0);
  assign apply_more   = apply_active && ((CNT_W'(ptr_r) + CNT_W'(1)) < count_r);

  // result word build
  always_comb begin
    out_c              = '0;
    out_c.live_entries = count_r;
    out_c.last         = 1'b1;
    case (item_r.mode)
      MODE_FREEZE: begin
        if (ok_r) begin
          out_c.ok          = 1'b1;
          out_c.write_valid = 1'b1;
          out_c.write_addr  = item_r.addr;
          out_c.write_data  = item_r.value;
        end
      end
      MODE_THAW: out_c.ok = ok_r;
      MODE_QUERY: begin
        if (hit_r) begin
          out_c.hit        = 1'b1;
          out_c.read_value = rd_r.value;
        end
      end
      MODE_READ: begin
        if (CNT_W'(item_r.index) < count_r) begin
          out_c.read_addr  = rd_r.addr;
          out_c.read_value = rd_r.value;
        end
      end
      MODE_APPLY: begin
        if (apply_active) begin
          out_c.write_valid = 1'b1;
          out_c.write_addr  = rd_r.addr;
          out_c.write_data  = rd_r.value;
          out_c.last        = ~apply_more;
        end
      end
      MODE_SET: begin
        out_c.ok          = 1'b1;
        out_c.write_valid = 1'b1;
        out_c.write_addr  = item_r.addr;
        out_c.write_data  = item_r.value;
      end
      default: out_c.ok = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data_r <= out_c;
  end

  assign sts.out_free   = ~out_valid_r | out_ready;
  assign sts.apply_more = apply_more;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

### rtl/memory_freeze_table_unit.sv
// Freeze table of up to 16 (address, byte) entries with a live count. Each
// input word selects freeze, thaw, query, read entry, apply or set by its
// mode field and produces one result word, except apply with the table
// enabled and non-empty, which produces one memory write word per entry in
// table order, the final one marked by last. An item is accepted in the
// idle step, then goes through compare, table read and update stages, and
// its first result is then loaded into the output register in the emit
// step; the next item can be accepted once that load happens. Apply
// repeats the read, data and emit steps the controller walks for each
// further entry. The output register decouples the result side; a stalled
// consumer holds the unit in its emit step. The enable register may be
// written only while the unit is idle.
module memory_freeze_table_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mft_pkg::mft_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mft_pkg::mft_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import mft_pkg::*;

  mft_cmd_t cmd;
  mft_sts_t sts;

  // sequencing
  mft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, compare and output register
  mft_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

### sim/memory_freeze_table_unit_tb.sv
module memory_freeze_table_unit_tb;
  import mft_pkg::*;

  // modes with no operation behind them
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int POOL_SIZE    = 20;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 28;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mft_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mft_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;

  memory_freeze_table_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the freeze table
  logic [15:0] shadow_addr [DEPTH];
  logic [7:0]  shadow_val  [DEPTH];
  int          shadow_count = 0;
  bit          apply_on = 1'b1;

  mft_out_t    step_words [$];
  mft_out_t    owed_results [$];

  int fails = 0;
  int words_sent = 0;
  int results_seen = 0;
  int full_refusals = 0;
  int apply_bursts = 0;
  int enable_writes = 0;
  int peak_fill = 0;
  int cycle_count = 0;

  logic [15:0] addr_pool [POOL_SIZE];

  // one row of the directed plan
  typedef struct {
    mft_in_t  word;
    int       reps;
    bit       typed;
    mft_out_t golden;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic mft_out_t result_word(bit ok, bit hit, logic [15:0] ra, logic [7:0] rv,
                                           bit wv, logic [15:0] wa, logic [7:0] wd, bit last);
    mft_out_t r;
    r.ok           = ok;
    r.hit          = hit;
    r.read_addr    = ra;
    r.read_value   = rv;
    r.write_valid  = wv;
    r.write_addr   = wa;
    r.write_data   = wd;
    r.live_entries = 5'(shadow_count);
    r.last         = last;
    return r;
  endfunction

  function automatic int find_entry(logic [15:0] a);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_addr[i] == a) return i;
    end
    return -1;
  endfunction

  // update the shadow table for one word and list the result words it owes
  function automatic void freeze_table_step(mft_in_t w);
    int s;
    step_words.delete();
    s = find_entry(w.addr);
    case (w.mode)
      MODE_FREEZE: begin
        if (s >= 0) begin
          shadow_val[s] = w.value;
          step_words.push_back(result_word(1, 0, 0, 0, 1, w.addr, w.value, 1));
        end else if (shadow_count < CAPACITY) begin
          shadow_addr[shadow_count] = w.addr;
          shadow_val[shadow_count]  = w.value;
          shadow_count++;
          step_words.push_back(result_word(1, 0, 0, 0, 1, w.addr, w.value, 1));
        end else begin
          full_refusals++;
          step_words.push_back(result_word(0, 0, 0, 0, 0, 0, 0, 1));
        end
      end
      MODE_THAW: begin
        if (s < 0) begin
          step_words.push_back(result_word(0, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          // last entry fills the hole
          shadow_addr[s] = shadow_addr[shadow_count - 1];
          shadow_val[s]  = shadow_val[shadow_count - 1];
          shadow_count--;
          step_words.push_back(result_word(1, 0, 0, 0, 0, 0, 0, 1));
        end
      end
      MODE_QUERY: begin
        if (s >= 0) step_words.push_back(result_word(0, 1, 0, shadow_val[s], 0, 0, 0, 1));
        else step_words.push_back(result_word(0, 0, 0, 0, 0, 0, 0, 1));
      end
      MODE_READ: begin
        if (int'(w.index) < shadow_count) begin
          step_words.push_back(result_word(0, 0, shadow_addr[w.index], shadow_val[w.index],
                                           0, 0, 0, 1));
        end else begin
          step_words.push_back(result_word(0, 0, 0, 0, 0, 0, 0, 1));
        end
      end
      MODE_APPLY: begin
        if (!apply_on || shadow_count == 0) begin
          step_words.push_back(result_word(0, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          apply_bursts++;
          for (int i = 0; i < shadow_count; i++) begin
            step_words.push_back(result_word(0, 0, 0, 0, 1, shadow_addr[i], shadow_val[i],
                                             i == shadow_count - 1));
          end
        end
      end
      MODE_SET: begin
        step_words.push_back(result_word(1, 0, 0, 0, 1, w.addr, w.value, 1));
      end
      default: begin
        step_words.push_back(result_word(0, 0, 0, 0, 0, 0, 0, 1));
      end
    endcase
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // result side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    mft_out_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        fails++;
      end else begin
        e = owed_results.pop_front();
        check_field("ok", 16'(e.ok), 16'(out_data.ok));
        check_field("hit", 16'(e.hit), 16'(out_data.hit));
        check_field("read_addr", e.read_addr, out_data.read_addr);
        check_field("read_value", 16'(e.read_value), 16'(out_data.read_value));
        check_field("write_valid", 16'(e.write_valid), 16'(out_data.write_valid));
        check_field("write_addr", e.write_addr, out_data.write_addr);
        check_field("write_data", 16'(e.write_data), 16'(out_data.write_data));
        check_field("live_entries", 16'(e.live_entries), 16'(out_data.live_entries));
        check_field("last", 16'(e.last), 16'(out_data.last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, some long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls, with long stretches of steady ready
  initial begin
    int run;
    int gap;
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      gap = idle_len();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // offer one word, wait for acceptance, then idle for the requested gap
  task automatic push_word(input mft_in_t w, input bit typed, input mft_out_t golden,
                           input int gap);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    freeze_table_step(w);
    if (typed) begin
      owed_results.push_back(golden);
    end else begin
      foreach (step_words[i]) owed_results.push_back(step_words[i]);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write the enable register once the unit has drained
  task automatic write_enable(input bit v);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_on = v;
    enable_writes++;
  endtask

  function automatic mft_out_t golden_word(bit ok, bit hit, logic [15:0] ra, logic [7:0] rv,
                                           bit wv, logic [15:0] wa, logic [7:0] wd,
                                           logic [4:0] live);
    mft_out_t r;
    r = '{ok, hit, ra, rv, wv, wa, wd, live, 1'b1};
    return r;
  endfunction

  function automatic void add_row(logic [2:0] mode, logic [15:0] a, logic [7:0] v,
                                  logic [3:0] idx, int reps, bit typed, mft_out_t golden);
    plan_row_t row;
    row.word   = '{mode, a, v, idx};
    row.reps   = reps;
    row.typed  = typed;
    row.golden = golden;
    plan.push_back(row);
  endfunction

  // random word: pool addresses for hits, fill-heavy or drain-heavy mix
  function automatic mft_in_t random_word(bit fill_heavy);
    mft_in_t w;
    int r;
    r = $urandom_range(0, 99);
    if (fill_heavy) begin
      if (r < 38) w.mode = MODE_FREEZE;
      else if (r < 48) w.mode = MODE_THAW;
      else if (r < 60) w.mode = MODE_QUERY;
      else if (r < 72) w.mode = MODE_READ;
      else if (r < 82) w.mode = MODE_APPLY;
      else if (r < 92) w.mode = MODE_SET;
      else w.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
    end else begin
      if (r < 15) w.mode = MODE_FREEZE;
      else if (r < 45) w.mode = MODE_THAW;
      else if (r < 60) w.mode = MODE_QUERY;
      else if (r < 72) w.mode = MODE_READ;
      else if (r < 82) w.mode = MODE_APPLY;
      else if (r < 92) w.mode = MODE_SET;
      else w.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
    end
    w.addr  = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : 16'($urandom);
    w.value = 8'($urandom_range(0, 255));
    w.index = 4'($urandom_range(0, 15));
    return w;
  endfunction

  initial begin
    mft_in_t w;
    int g;
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = 16'($urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_enable(1'b1);

    // directed plan: empty table, extremes, fill to capacity, apply all, thaw
    add_row(MODE_QUERY, 16'h1234, 8'h00, 4'h0, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_READ, 16'h0000, 8'h00, 4'h0, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_APPLY, 16'h0000, 8'h00, 4'h0, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_THAW, 16'hFFFF, 8'h00, 4'hF, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_SET, 16'hFFFF, 8'hFF, 4'h0, 1, 1,
            golden_word(1, 0, 0, 0, 1, 16'hFFFF, 8'hFF, 0));
    add_row(MODE_SET, 16'h0000, 8'h00, 4'hF, 1, 1, golden_word(1, 0, 0, 0, 1, 0, 0, 0));
    add_row(MODE_SPARE6, 16'hFFFF, 8'hFF, 4'hF, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_SPARE7, 16'h5555, 8'hAA, 4'h5, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_FREEZE, 16'h0000, 8'h00, 4'h0, 1, 1, golden_word(1, 0, 0, 0, 1, 0, 0, 1));
    add_row(MODE_FREEZE, 16'hFFFF, 8'hFF, 4'hF, 1, 1,
            golden_word(1, 0, 0, 0, 1, 16'hFFFF, 8'hFF, 2));
    add_row(MODE_FREEZE, 16'h0000, 8'h5A, 4'h0, 1, 1,
            golden_word(1, 0, 0, 0, 1, 16'h0000, 8'h5A, 2));
    add_row(MODE_QUERY, 16'hFFFF, 8'h00, 4'h0, 1, 1,
            golden_word(0, 1, 0, 8'hFF, 0, 0, 0, 2));
    add_row(MODE_READ, 16'h0000, 8'h00, 4'h1, 1, 1,
            golden_word(0, 0, 16'hFFFF, 8'hFF, 0, 0, 0, 2));
    add_row(MODE_FREEZE, 16'h0100, 8'h31, 4'h0, 14, 0, '0);
    add_row(MODE_FREEZE, 16'hBEEF, 8'h99, 4'h0, 1, 1, golden_word(0, 0, 0, 0, 0, 0, 0, 16));
    add_row(MODE_FREEZE, 16'h0105, 8'h77, 4'h0, 1, 0, '0);
    add_row(MODE_READ, 16'h0000, 8'h00, 4'hF, 1, 0, '0);
    add_row(MODE_APPLY, 16'h0000, 8'h00, 4'h0, 1, 0, '0);
    add_row(MODE_THAW, 16'h0000, 8'h00, 4'h0, 1, 1, golden_word(1, 0, 0, 0, 0, 0, 0, 15));
    add_row(MODE_READ, 16'h0000, 8'h00, 4'h0, 1, 0, '0);
    add_row(MODE_THAW, 16'h0105, 8'h00, 4'h0, 1, 0, '0);
    add_row(MODE_QUERY, 16'h0000, 8'h00, 4'h0, 1, 0, '0);
    add_row(MODE_READ, 16'h0000, 8'h00, 4'hF, 1, 0, '0);

    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++) begin
        w = plan[i].word;
        w.addr = w.addr + 16'(r);
        g = idle_len();
        if (i == plan.size() - 1 && r == plan[i].reps - 1 && g == 0) g = 1;
        push_word(w, plan[i].typed, plan[i].golden, g);
      end
    end

    // random phases, enable toggling between them, sender drains before each write
    for (int p = 0; p < PHASES; p++) begin
      write_enable(p % 2 == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w = random_word(p != 2 && p != 5);
        g = (p == 3) ? 0 : idle_len();
        if (n == PHASE_WORDS - 1 && g == 0) g = 1;
        push_word(w, 0, '0, g);
      end
    end

    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words, checked %0d result words, %0d apply bursts, %0d enable writes",
             words_sent, results_seen, apply_bursts, enable_writes);
    $display("table peaked at %0d entries, %0d freezes refused on a full table",
             peak_fill, full_refusals);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
